FILE: rtl/csl_pkg.sv
package csl_pkg;

	localparam int TW = 44;
	localparam int SW = 52;
	localparam int QW = 96;
	localparam int MAW = 104;
	localparam int MBW = 56;
	localparam int MPW = MAW + MBW;
	localparam int MDG = 8;
	localparam int MUL_STEPS = MBW / MDG;
	localparam int MCW = $clog2(MUL_STEPS);
	localparam int EW = 106;
	localparam int DNW = 136;
	localparam int DVW = 105;
	localparam int DQW = 47;
	localparam int DCW = $clog2(DNW);
	localparam int OW = 45;
	localparam int SLW = 32;
	localparam int THW = 21;
	localparam logic [THW-1:0] THR_RESET = 21'd20972;
	localparam logic REG_THRESHOLD = 1'b0;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_CLEAR,
		OP_READ,
		OP_MUL_XX,
		OP_MUL_XY,
		OP_MUL_NXX,
		OP_MUL_SXSX,
		OP_MUL_NXY,
		OP_MUL_SXSY,
		OP_MUL_SLSX,
		OP_MUL_MAP,
		OP_TAKE_XX,
		OP_TAKE_XY,
		OP_TAKE_NXX,
		OP_TAKE_DEN,
		OP_TAKE_NXY,
		OP_TAKE_NUM,
		OP_TAKE_OFFN,
		OP_DIV_SLOPE,
		OP_DIV_OFFSET,
		OP_TAKE_SLOPE,
		OP_TAKE_OFFSET,
		OP_TAKE_MAP,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic mul_busy;
		logic div_busy;
		logic n_lt2;
		logic last_pt;
		logic den_ok;
		logic stale;
		logic out_full;
	} dp_status_t;

	function automatic logic [OW-1:0] sat45(input logic [49:0] x);
		logic [OW-1:0] r;
		if (x[49:44] == 6'h00 || x[49:44] == 6'h3F) begin
			r = x[OW-1:0];
		end else if (x[49]) begin
			r = 45'h100000000000;
		end else begin
			r = 45'h0FFFFFFFFFFF;
		end
		return r;
	endfunction

endpackage

FILE: rtl/csl_mul.sv
module csl_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [csl_pkg::MAW-1:0]  a,
	input  logic [csl_pkg::MBW-1:0]  b,
	output logic                     busy,
	output logic [csl_pkg::MPW-1:0]  p
);

	logic                            busy_q;
	logic [csl_pkg::MCW-1:0]         cnt_q;
	logic [csl_pkg::MAW-1:0]         a_q;
	logic [csl_pkg::MBW-1:0]         b_q;
	logic [csl_pkg::MPW-1:0]         p_q;
	logic [csl_pkg::MAW+csl_pkg::MDG-1:0] pp;

	// radix-256 shift-add, MSB digit first
	always_comb begin
		pp = a_q * b_q[csl_pkg::MBW-1 -: csl_pkg::MDG];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= csl_pkg::MCW'(csl_pkg::MUL_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= (p_q << csl_pkg::MDG) + csl_pkg::MPW'(pp);
			b_q <= b_q << csl_pkg::MDG;
		end
	end

	assign busy = busy_q;
	assign p    = p_q;

endmodule

FILE: rtl/csl_div.sv
module csl_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [csl_pkg::DNW-1:0]  n,
	input  logic [csl_pkg::DVW-1:0]  d,
	output logic                     busy,
	output logic [csl_pkg::DQW-1:0]  q,
	output logic                     ovf
);

	logic                        busy_q;
	logic [csl_pkg::DCW-1:0]     cnt_q;
	logic [csl_pkg::DNW-1:0]     n_q;
	logic [csl_pkg::DVW-1:0]     d_q;
	logic [csl_pkg::DVW-1:0]     r_q;
	logic [csl_pkg::DQW-1:0]     q_q;
	logic                        ovf_q;
	logic [csl_pkg::DVW:0]       rs;
	logic [csl_pkg::DVW:0]       r_nx;
	logic                        ge;

	// restoring division, one quotient bit per cycle
	always_comb begin
		rs   = {r_q, n_q[csl_pkg::DNW-1]};
		ge   = rs >= {1'b0, d_q};
		r_nx = ge ? rs - {1'b0, d_q} : rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= csl_pkg::DCW'(csl_pkg::DNW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			r_q   <= r_nx[csl_pkg::DVW-1:0];
			q_q   <= {q_q[csl_pkg::DQW-2:0], ge};
			ovf_q <= ovf_q | q_q[csl_pkg::DQW-1];
		end
	end

	assign busy = busy_q;
	assign q    = q_q;
	assign ovf  = ovf_q;

endmodule

FILE: rtl/csl_datapath.sv
module csl_datapath #(
	parameter int POINT_COUNT = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  csl_pkg::dp_op_t              op,
	input  logic                         cmd,
	input  logic [csl_pkg::TW-1:0]       local_time,
	input  logic [csl_pkg::TW-1:0]       reference_time,
	input  logic [csl_pkg::THW-1:0]      threshold,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic signed [csl_pkg::OW-1:0] mapped_time,
	output logic signed [csl_pkg::OW-1:0] deviation,
	output logic                         accepted,
	output csl_pkg::dp_status_t          status
);

	localparam int IW = $clog2(POINT_COUNT);
	localparam int CW = $clog2(POINT_COUNT + 1);

	logic                        cmd_q;
	logic [csl_pkg::TW-1:0]      loc_q, ref_q;
	logic [csl_pkg::TW-1:0]      loc_mem [POINT_COUNT];
	logic [csl_pkg::TW-1:0]      ref_mem [POINT_COUNT];
	logic [csl_pkg::TW-1:0]      rd_loc_q, rd_ref_q;
	logic [csl_pkg::SW-1:0]      sx_q, sy_q;
	logic [csl_pkg::QW-1:0]      sxx_q, sxy_q;
	logic [csl_pkg::MAW-1:0]     t0_q;
	logic [csl_pkg::EW-1:0]      den_q, num_q;
	logic [csl_pkg::SLW-1:0]     slope_q;
	logic [csl_pkg::OW-1:0]      offset_q;
	logic [IW-1:0]               idx_q, wr_idx_q;
	logic                        full_q, stale_q;
	logic                        out_valid_q;
	logic [csl_pkg::OW-1:0]      mapped_q, dev_q;
	logic                        acc_q;
	logic [49:0]                 mf_q;

	logic                        mul_start, mul_busy;
	logic [csl_pkg::MAW-1:0]     mul_a;
	logic [csl_pkg::MBW-1:0]     mul_b;
	logic [csl_pkg::MPW-1:0]     mul_p;
	logic                        div_start, div_busy, div_ovf;
	logic [csl_pkg::DNW-1:0]     div_n;
	logic [csl_pkg::DVW-1:0]     div_d;
	logic [csl_pkg::DQW-1:0]     div_q;

	logic [CW-1:0]               n_pts;
	logic [32:0]                 slope_ext, slope_mag;
	logic [csl_pkg::EW-1:0]      num_abs;
	logic [csl_pkg::EW-1:0]      sy_sh;
	logic [76:0]                 p_rnd;
	logic [46:0]                 rnd_mag;
	logic [47:0]                 rnd_s;
	logic [49:0]                 mf, dv, dmag;
	logic                        keep;

	assign n_pts     = full_q ? CW'(POINT_COUNT) : CW'(wr_idx_q);
	assign slope_ext = {slope_q[csl_pkg::SLW-1], slope_q};
	assign slope_mag = slope_q[csl_pkg::SLW-1] ? 33'd0 - slope_ext : slope_ext;
	assign num_abs   = num_q[csl_pkg::EW-1] ? csl_pkg::EW'(0) - num_q : num_q;
	assign sy_sh     = csl_pkg::EW'(sy_q) << 30;

	// mapping: round half away from zero, then add offset
	always_comb begin
		p_rnd   = mul_p[76:0] + (77'(1) << 29);
		rnd_mag = p_rnd[76:30];
		rnd_s   = slope_q[csl_pkg::SLW-1] ? 48'd0 - {1'b0, rnd_mag} : {1'b0, rnd_mag};
		mf      = {{2{rnd_s[47]}}, rnd_s} + {{5{offset_q[csl_pkg::OW-1]}}, offset_q};
		dv      = mf_q - {6'd0, ref_q};
		dmag    = dv[49] ? 50'd0 - dv : dv;
		keep    = cmd_q && ((dmag < 50'(threshold)) || !full_q);
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		case (op)
			csl_pkg::OP_MUL_XX: begin
				mul_start = 1'b1;
				mul_a     = csl_pkg::MAW'(rd_loc_q);
				mul_b     = csl_pkg::MBW'(rd_loc_q);
			end
			csl_pkg::OP_MUL_XY: begin
				mul_start = 1'b1;
				mul_a     = csl_pkg::MAW'(rd_loc_q);
				mul_b     = csl_pkg::MBW'(rd_ref_q);
			end
			csl_pkg::OP_MUL_NXX: begin
				mul_start = 1'b1;
				mul_a     = csl_pkg::MAW'(sxx_q);
				mul_b     = csl_pkg::MBW'(n_pts);
			end
			csl_pkg::OP_MUL_SXSX: begin
				mul_start = 1'b1;
				mul_a     = csl_pkg::MAW'(sx_q);
				mul_b     = csl_pkg::MBW'(sx_q);
			end
			csl_pkg::OP_MUL_NXY: begin
				mul_start = 1'b1;
				mul_a     = csl_pkg::MAW'(sxy_q);
				mul_b     = csl_pkg::MBW'(n_pts);
			end
			csl_pkg::OP_MUL_SXSY: begin
				mul_start = 1'b1;
				mul_a     = csl_pkg::MAW'(sx_q);
				mul_b     = csl_pkg::MBW'(sy_q);
			end
			csl_pkg::OP_MUL_SLSX: begin
				mul_start = 1'b1;
				mul_a     = csl_pkg::MAW'(sx_q);
				mul_b     = csl_pkg::MBW'(slope_mag);
			end
			csl_pkg::OP_MUL_MAP: begin
				mul_start = 1'b1;
				mul_a     = csl_pkg::MAW'(loc_q);
				mul_b     = csl_pkg::MBW'(slope_mag);
			end
			csl_pkg::OP_DIV_SLOPE: begin
				div_start = 1'b1;
				div_n     = (csl_pkg::DNW'(num_abs) << 31) + csl_pkg::DNW'(den_q);
				div_d     = {den_q[csl_pkg::DVW-2:0], 1'b0};
			end
			csl_pkg::OP_DIV_OFFSET: begin
				div_start = 1'b1;
				div_n     = (csl_pkg::DNW'(num_abs) << 1) + (csl_pkg::DNW'(n_pts) << 30);
				div_d     = csl_pkg::DVW'(n_pts) << 31;
			end
			default: begin
			end
		endcase
	end

	csl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.p      (mul_p)
	);

	csl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.busy   (div_busy),
		.q      (div_q),
		.ovf    (div_ovf)
	);

	// fit and ring control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			full_q      <= 1'b0;
			stale_q     <= 1'b1;
			slope_q     <= '0;
			offset_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == csl_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (op)
				csl_pkg::OP_CLEAR: begin
					idx_q   <= '0;
					stale_q <= 1'b0;
				end
				csl_pkg::OP_TAKE_XY: begin
					idx_q <= idx_q + 1'b1;
				end
				csl_pkg::OP_TAKE_SLOPE: begin
					if (num_q[csl_pkg::EW-1]) begin
						if (div_ovf || div_q > 47'h000080000000) begin
							slope_q <= 32'h80000000;
						end else begin
							slope_q <= csl_pkg::SLW'(47'd0 - div_q);
						end
					end else begin
						if (div_ovf || div_q > 47'h00007FFFFFFF) begin
							slope_q <= 32'h7FFFFFFF;
						end else begin
							slope_q <= csl_pkg::SLW'(div_q);
						end
					end
				end
				csl_pkg::OP_TAKE_OFFSET: begin
					if (num_q[csl_pkg::EW-1]) begin
						if (div_ovf || div_q > 47'h100000000000) begin
							offset_q <= 45'h100000000000;
						end else begin
							offset_q <= csl_pkg::OW'(47'd0 - div_q);
						end
					end else begin
						if (div_ovf || div_q > 47'h0FFFFFFFFFFF) begin
							offset_q <= 45'h0FFFFFFFFFFF;
						end else begin
							offset_q <= csl_pkg::OW'(div_q);
						end
					end
				end
				csl_pkg::OP_EMIT: begin
					if (keep) begin
						stale_q <= 1'b1;
						if (wr_idx_q == IW'(POINT_COUNT - 1)) begin
							wr_idx_q <= '0;
							full_q   <= 1'b1;
						end else begin
							wr_idx_q <= wr_idx_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers and ring memory
	always_ff @(posedge clk) begin
		unique case (op)
			csl_pkg::OP_LOAD: begin
				cmd_q <= cmd;
				loc_q <= local_time;
				ref_q <= reference_time;
			end
			csl_pkg::OP_CLEAR: begin
				sx_q  <= '0;
				sy_q  <= '0;
				sxx_q <= '0;
				sxy_q <= '0;
			end
			csl_pkg::OP_READ: begin
				rd_loc_q <= loc_mem[idx_q];
				rd_ref_q <= ref_mem[idx_q];
			end
			csl_pkg::OP_TAKE_XX: begin
				sxx_q <= sxx_q + csl_pkg::QW'(mul_p);
				sx_q  <= sx_q + csl_pkg::SW'(rd_loc_q);
				sy_q  <= sy_q + csl_pkg::SW'(rd_ref_q);
			end
			csl_pkg::OP_TAKE_XY: begin
				sxy_q <= sxy_q + csl_pkg::QW'(mul_p);
			end
			csl_pkg::OP_TAKE_NXX, csl_pkg::OP_TAKE_NXY: begin
				t0_q <= csl_pkg::MAW'(mul_p);
			end
			csl_pkg::OP_TAKE_DEN: begin
				den_q <= csl_pkg::EW'(t0_q) - csl_pkg::EW'(mul_p);
			end
			csl_pkg::OP_TAKE_NUM: begin
				num_q <= csl_pkg::EW'(t0_q) - csl_pkg::EW'(mul_p);
			end
			csl_pkg::OP_TAKE_OFFN: begin
				num_q <= slope_q[csl_pkg::SLW-1] ? sy_sh + csl_pkg::EW'(mul_p)
					: sy_sh - csl_pkg::EW'(mul_p);
			end
			csl_pkg::OP_TAKE_MAP: begin
				mf_q <= mf;
			end
			csl_pkg::OP_EMIT: begin
				mapped_q <= csl_pkg::sat45(mf_q);
				dev_q    <= cmd_q ? csl_pkg::sat45(dv) : '0;
				acc_q    <= keep;
				if (keep) begin
					loc_mem[wr_idx_q] <= loc_q;
					ref_mem[wr_idx_q] <= ref_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign mapped_time = mapped_q;
	assign deviation   = dev_q;
	assign accepted    = acc_q;

	assign status.mul_busy = mul_busy;
	assign status.div_busy = div_busy;
	assign status.n_lt2    = n_pts < CW'(2);
	assign status.last_pt  = CW'(idx_q) == n_pts - CW'(1);
	assign status.den_ok   = !den_q[csl_pkg::EW-1] && (den_q != '0);
	assign status.stale    = stale_q;
	assign status.out_full = out_valid_q && !out_ready;

endmodule

FILE: rtl/csl_ctrl.sv
module csl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  csl_pkg::dp_status_t  status,
	output csl_pkg::dp_op_t      op
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_MXX,
		ST_WXX,
		ST_MXY,
		ST_WXY,
		ST_NXX,
		ST_WNXX,
		ST_SXSX,
		ST_WSXSX,
		ST_CHK,
		ST_NXY,
		ST_WNXY,
		ST_SXSY,
		ST_WSXSY,
		ST_DS,
		ST_WDS,
		ST_SLSX,
		ST_WSLSX,
		ST_DO,
		ST_WDO,
		ST_MAP,
		ST_WMAP,
		ST_EMIT
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		op       = csl_pkg::OP_NOP;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op       = csl_pkg::OP_LOAD;
					state_nx = status.stale ? ST_CLEAR : ST_MAP;
				end
			end
			ST_CLEAR: begin
				op       = csl_pkg::OP_CLEAR;
				state_nx = status.n_lt2 ? ST_MAP : ST_READ;
			end
			ST_READ: begin
				op       = csl_pkg::OP_READ;
				state_nx = ST_MXX;
			end
			ST_MXX: begin
				op       = csl_pkg::OP_MUL_XX;
				state_nx = ST_WXX;
			end
			ST_WXX: begin
				if (!status.mul_busy) begin
					op       = csl_pkg::OP_TAKE_XX;
					state_nx = ST_MXY;
				end
			end
			ST_MXY: begin
				op       = csl_pkg::OP_MUL_XY;
				state_nx = ST_WXY;
			end
			ST_WXY: begin
				if (!status.mul_busy) begin
					op       = csl_pkg::OP_TAKE_XY;
					state_nx = status.last_pt ? ST_NXX : ST_READ;
				end
			end
			ST_NXX: begin
				op       = csl_pkg::OP_MUL_NXX;
				state_nx = ST_WNXX;
			end
			ST_WNXX: begin
				if (!status.mul_busy) begin
					op       = csl_pkg::OP_TAKE_NXX;
					state_nx = ST_SXSX;
				end
			end
			ST_SXSX: begin
				op       = csl_pkg::OP_MUL_SXSX;
				state_nx = ST_WSXSX;
			end
			ST_WSXSX: begin
				if (!status.mul_busy) begin
					op       = csl_pkg::OP_TAKE_DEN;
					state_nx = ST_CHK;
				end
			end
			ST_CHK: begin
				state_nx = status.den_ok ? ST_NXY : ST_MAP;
			end
			ST_NXY: begin
				op       = csl_pkg::OP_MUL_NXY;
				state_nx = ST_WNXY;
			end
			ST_WNXY: begin
				if (!status.mul_busy) begin
					op       = csl_pkg::OP_TAKE_NXY;
					state_nx = ST_SXSY;
				end
			end
			ST_SXSY: begin
				op       = csl_pkg::OP_MUL_SXSY;
				state_nx = ST_WSXSY;
			end
			ST_WSXSY: begin
				if (!status.mul_busy) begin
					op       = csl_pkg::OP_TAKE_NUM;
					state_nx = ST_DS;
				end
			end
			ST_DS: begin
				op       = csl_pkg::OP_DIV_SLOPE;
				state_nx = ST_WDS;
			end
			ST_WDS: begin
				if (!status.div_busy) begin
					op       = csl_pkg::OP_TAKE_SLOPE;
					state_nx = ST_SLSX;
				end
			end
			ST_SLSX: begin
				op       = csl_pkg::OP_MUL_SLSX;
				state_nx = ST_WSLSX;
			end
			ST_WSLSX: begin
				if (!status.mul_busy) begin
					op       = csl_pkg::OP_TAKE_OFFN;
					state_nx = ST_DO;
				end
			end
			ST_DO: begin
				op       = csl_pkg::OP_DIV_OFFSET;
				state_nx = ST_WDO;
			end
			ST_WDO: begin
				if (!status.div_busy) begin
					op       = csl_pkg::OP_TAKE_OFFSET;
					state_nx = ST_MAP;
				end
			end
			ST_MAP: begin
				op       = csl_pkg::OP_MUL_MAP;
				state_nx = ST_WMAP;
			end
			ST_WMAP: begin
				if (!status.mul_busy) begin
					op       = csl_pkg::OP_TAKE_MAP;
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!status.out_full) begin
					op       = csl_pkg::OP_EMIT;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = state_q == ST_IDLE;

endmodule

FILE: rtl/clock_sync_linear_regression_core.sv
// channel | signals                                         | direction
// config  | psel penable pwrite paddr pwdata prdata pready   | APB slave
// input   | in_valid in_ready cmd local_time reference_time  | word in
// output  | out_valid out_ready mapped_time deviation accepted | word out
//
// One word at a time. With a fresh fit a word needs a single product from
// the 7-step shared multiplier. After a stored update the next word refits:
// two products per stored pair, then the fit itself, including the two
// 136-step divisions. A waiting result stalls only the end of the next word.
// Reset clears the fit to zero slope and offset and empties the ring.
module clock_sync_linear_regression_core #(
	parameter int POINT_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [csl_pkg::TW-1:0]        local_time,
	input  logic [csl_pkg::TW-1:0]        reference_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [csl_pkg::OW-1:0] mapped_time,
	output logic signed [csl_pkg::OW-1:0] deviation,
	output logic                          accepted
);

	logic [csl_pkg::THW-1:0] thr_q;
	csl_pkg::dp_op_t         op;
	csl_pkg::dp_status_t     status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= csl_pkg::THR_RESET;
		end else if (psel && penable && pwrite && paddr[2] == csl_pkg::REG_THRESHOLD) begin
			thr_q <= pwdata[csl_pkg::THW-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == csl_pkg::REG_THRESHOLD) ? 32'(thr_q) : 32'd0;

	csl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.op       (op)
	);

	csl_datapath #(
		.POINT_COUNT (POINT_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.cmd            (cmd),
		.local_time     (local_time),
		.reference_time (reference_time),
		.threshold      (thr_q),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.mapped_time    (mapped_time),
		.deviation      (deviation),
		.accepted       (accepted),
		.status         (status)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while previous word in flight");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.mul_busy && status.div_busy))
		else $error("multiplier and divider busy together");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in flight");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic                   cmd;
		logic [csl_pkg::TW-1:0] lt;
		logic [csl_pkg::TW-1:0] rt;
	} word_t;

	typedef struct {
		logic [csl_pkg::OW-1:0] mapped;
		logic [csl_pkg::OW-1:0] dev;
		logic                   acc;
	} fix_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              psel = 0;
	logic              penable = 0;
	logic              pwrite = 0;
	logic [2:0]        paddr = 0;
	logic [31:0]       pwdata = 0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 0;
	logic              in_ready;
	logic              cmd = 0;
	logic [csl_pkg::TW-1:0] local_time = 0;
	logic [csl_pkg::TW-1:0] reference_time = 0;
	logic              out_valid;
	logic              out_ready = 0;
	logic signed [csl_pkg::OW-1:0] mapped_time;
	logic signed [csl_pkg::OW-1:0] deviation;
	logic              accepted;

	clock_sync_linear_regression_core uut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [csl_pkg::TW-1:0] ring_loc [16];
	logic [csl_pkg::TW-1:0] ring_ref [16];
	int                ring_wr;
	bit                ring_full;
	bit                fit_stale;
	logic signed [31:0] fit_slope;
	wide_t             fit_offset;
	logic [csl_pkg::THW-1:0] dev_thr;

	word_t             pend_q[$];
	fix_t              fix_q[$];
	int                errors = 0;
	int                n_words = 0, n_stored = 0, n_dropped = 0, n_query = 0;
	bit                steady = 0;
	bit                hold_go = 0, hold_done = 0;
	int                hold_cnt = 0;

	function automatic wide_t div_rnd(wide_t num, wide_t den);
		wide_t m, q;
		m = (num < 0) ? -num : num;
		q = (m + m + den) / (den + den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic wide_t clampw(wide_t a, wide_t lo, wide_t hi);
		if (a < lo) return lo;
		if (a > hi) return hi;
		return a;
	endfunction

	function automatic logic [csl_pkg::OW-1:0] sat_q20(wide_t a);
		wide_t lo, hi, r;
		hi = (wide_t'(1) <<< 44) - 1;
		lo = -hi - 1;
		r = clampw(a, lo, hi);
		return r[csl_pkg::OW-1:0];
	endfunction

	task automatic refit_line();
		int n;
		wide_t sx, sy, sxx, sxy, xv, yv, wn, den, num, sl, offn, q, hi45, lo45, hi32, lo32;
		n = ring_full ? 16 : ring_wr;
		fit_stale = 0;
		if (n < 2) return;
		sx = 0; sy = 0; sxx = 0; sxy = 0;
		for (int i = 0; i < n; i++) begin
			xv = ring_loc[i];
			yv = ring_ref[i];
			sx += xv; sy += yv; sxx += xv * xv; sxy += xv * yv;
		end
		wn = n;
		q = wide_t'(1) <<< 30;
		den = wn * sxx - sx * sx;
		if (den <= 0) return;
		num = wn * sxy - sx * sy;
		hi32 = (wide_t'(1) <<< 31) - 1;
		lo32 = -hi32 - 1;
		sl = clampw(div_rnd(num * q, den), lo32, hi32);
		offn = sy * q - sl * sx;
		hi45 = (wide_t'(1) <<< 44) - 1;
		lo45 = -hi45 - 1;
		fit_slope = sl[31:0];
		fit_offset = clampw(div_rnd(offn, wn * q), lo45, hi45);
	endtask

	task automatic predict_word(word_t w);
		fix_t f;
		wide_t sw, lv, rv, mp, d, mag;
		if (fit_stale) refit_line();
		sw = fit_slope;
		lv = w.lt;
		rv = w.rt;
		mp = div_rnd(sw * lv, wide_t'(1) <<< 30) + fit_offset;
		f.mapped = sat_q20(mp);
		f.dev = '0;
		f.acc = 0;
		if (w.cmd) begin
			d = mp - rv;
			mag = (d < 0) ? -d : d;
			f.dev = sat_q20(d);
			if (mag < dev_thr || !ring_full) begin
				ring_loc[ring_wr] = w.lt;
				ring_ref[ring_wr] = w.rt;
				ring_wr++;
				if (ring_wr >= 16) begin
					ring_wr = 0;
					ring_full = 1;
				end
				fit_stale = 1;
				f.acc = 1;
				n_stored++;
			end else begin
				n_dropped++;
			end
		end else begin
			n_query++;
		end
		n_words++;
		fix_q.push_back(f);
	endtask

	task automatic report(string what, logic [csl_pkg::OW-1:0] got,
		logic [csl_pkg::OW-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		word_t w;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				w.cmd = cmd; w.lt = local_time; w.rt = reference_time;
				predict_word(w);
			end
			if (!in_valid || in_ready) begin
				if (pend_q.size() > 0 && (steady || $urandom_range(99) >= 7)) begin
					w = pend_q.pop_front();
					in_valid <= 1;
					cmd <= w.cmd;
					local_time <= w.lt;
					reference_time <= w.rt;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			if (hold_cnt == 3000) hold_done <= 1;
			else hold_cnt <= hold_cnt + 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		fix_t f;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (fix_q.size() == 0) begin
					$display("unexpected output word at %0t", $realtime);
					errors++;
				end else begin
					f = fix_q.pop_front();
					if (mapped_time !== f.mapped) report("mapped_time", mapped_time, f.mapped);
					if (deviation !== f.dev) report("deviation", deviation, f.dev);
					if (accepted !== f.acc) begin
						report("accepted", csl_pkg::OW'(accepted), csl_pkg::OW'(f.acc));
					end
				end
			end
			out_ready <= !(hold_go && !hold_done) && (steady || $urandom_range(99) >= 7);
		end
	end

	task automatic push_word(logic c, logic [csl_pkg::TW-1:0] lt, logic [csl_pkg::TW-1:0] rt);
		word_t w;
		w.cmd = c; w.lt = lt; w.rt = rt;
		pend_q.push_back(w);
	endtask

	function automatic logic [csl_pkg::TW-1:0] rnd44();
		return csl_pkg::TW'({$urandom, $urandom});
	endfunction

	task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == 3'(csl_pkg::REG_THRESHOLD)) dev_thr = data[csl_pkg::THW-1:0];
	endtask

	task automatic drain();
		while (pend_q.size() > 0 || in_valid || fix_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// linear clock track with skew, jitter, outliers, queries and noise
	task automatic gen_track(int cnt, int jit, int outl, int qpct, int noise);
		longint t, skew, rt, j;
		logic [csl_pkg::TW-1:0] lb, rb;
		int r;
		lb = rnd44() >> 2;
		rb = rnd44() >> 2;
		skew = longint'($urandom_range(0, 4000)) - 2000;
		t = 0;
		for (int i = 0; i < cnt; i++) begin
			t += $urandom_range(1 << 16, 1 << 22);
			j = longint'($urandom_range(0, 2 * jit)) - jit;
			if ($urandom_range(99) < outl)
				j += longint'($urandom_range(0, 1 << 22)) - (1 << 21);
			rt = longint'(rb) + t + ((t * skew) >>> 20) + j;
			r = $urandom_range(99);
			if (r < noise) push_word(1'($urandom_range(1)), rnd44(), rnd44());
			else if (r < noise + qpct) push_word(1'b0, csl_pkg::TW'(lb + t), rnd44());
			else push_word(1'b1, csl_pkg::TW'(lb + t), rt[csl_pkg::TW-1:0]);
		end
	endtask

	initial begin
		ring_wr = 0; ring_full = 0; fit_stale = 1;
		fit_slope = 0; fit_offset = 0; dev_thr = csl_pkg::THR_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset fit, single point, equal local times, saturation
		push_word(1'b0, '0, '1);
		push_word(1'b0, '1, '0);
		push_word(1'b1, '0, '0);
		push_word(1'b1, '0, 44'd5);
		push_word(1'b0, 44'd12345, '0);
		push_word(1'b1, 44'd1 << 20, 44'd1 << 21);
		push_word(1'b0, '1, '0);
		push_word(1'b1, '1, '0);
		push_word(1'b0, '1, '1);
		push_word(1'b1, '0, '1);
		push_word(1'b0, '0, '0);
		push_word(1'b1, 44'h555_5555_5555, 44'haaa_aaaa_aaaa);
		push_word(1'b1, 44'haaa_aaaa_aaaa, 44'h555_5555_5555);
		push_word(1'b0, 44'h800_0000_0000, '0);
		drain();

		cfg_write(3'(csl_pkg::REG_THRESHOLD), 32'(csl_pkg::THR_RESET));
		gen_track(120, 15000, 5, 30, 3);
		drain();

		cfg_write(3'd4, 32'hFFFF_FFFF);
		cfg_write(3'(csl_pkg::REG_THRESHOLD), 32'd0);
		gen_track(60, 100, 0, 20, 5);
		drain();

		cfg_write(3'(csl_pkg::REG_THRESHOLD), 32'd1048576);
		gen_track(120, 400000, 10, 25, 10);
		drain();

		cfg_write(3'(csl_pkg::REG_THRESHOLD), 32'hFFE0_0000 | $urandom_range(5000, 40000));
		hold_go <= 1;
		gen_track(150, 20000, 8, 30, 5);
		drain();

		cfg_write(3'(csl_pkg::REG_THRESHOLD), $urandom_range(0, 1048576));
		steady = 1;
		gen_track(150, 30000, 10, 30, 5);
		drain();
		steady = 0;

		cfg_write(3'(csl_pkg::REG_THRESHOLD), $urandom_range(1000, 60000));
		gen_track(200, 25000, 10, 30, 8);
		drain();
		repeat (50) @(posedge clk);

		$display("ran %0d words: %0d queries, %0d pairs stored, %0d dropped",
			n_words, n_query, n_stored, n_dropped);
		$display("thresholds swept from 0 to full scale, with a long output stall");
		if (errors == 0 && fix_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end

endmodule
